// ===== hw/rtl/imm_pkg.sv =====
// ----------------------------------------------------------------------------
// imm_pkg
// Shared types, constants and helpers of the integer matrix multiply engine.
// ----------------------------------------------------------------------------
`default_nettype none

package imm_pkg;

  localparam int unsigned MaxDim     = 16;
  localparam int unsigned IdxW       = 4;
  localparam int unsigned SizeW      = 5;
  localparam int unsigned KindW      = 2;
  localparam int unsigned StatusW    = 2;
  localparam int unsigned RegIdxW    = 2;
  localparam int unsigned ElemW      = 64;
  localparam int unsigned HalfW      = ElemW / 2;
  localparam int unsigned PartW      = 2 * (HalfW + 1);
  localparam int unsigned AccW       = 2 * ElemW;
  localparam int unsigned StoreDepth = MaxDim * MaxDim;
  localparam int unsigned AddrW      = $clog2(StoreDepth);

  typedef enum logic [KindW-1:0] {
    KindWriteA = 2'd0,
    KindWriteB = 2'd1,
    KindRead   = 2'd2
  } kind_e;

  typedef enum logic [StatusW-1:0] {
    StatusWriteOk = 2'd0,
    StatusValid   = 2'd1,
    StatusRange   = 2'd2
  } status_e;

  typedef enum logic [RegIdxW-1:0] {
    RegRows  = 2'd0,
    RegInner = 2'd1,
    RegCols  = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    StIdle,
    StMac,
    StFlush,
    StEmit
  } state_e;

  typedef struct packed {
    logic [KindW-1:0]        kind;
    logic [IdxW-1:0]         row_index;
    logic [IdxW-1:0]         column_index;
    logic signed [ElemW-1:0] element_value;
  } item_t;

  typedef struct packed {
    logic [StatusW-1:0]      status;
    logic [ElemW-1:0]        result_low;
    logic signed [ElemW-1:0] result_high;
  } result_t;

  typedef struct packed {
    logic [RegIdxW-1:0] index;
    logic [SizeW-1:0]   value;
  } cfg_t;

  function automatic logic [SizeW-1:0] eff_size(input logic [SizeW-1:0] raw);
    logic [SizeW-1:0] res;
    res = raw;
    if (raw == '0) begin
      res = SizeW'(1);
    end else if (raw > SizeW'(MaxDim)) begin
      res = SizeW'(MaxDim);
    end
    return res;
  endfunction

  function automatic logic [AddrW-1:0] entry_addr(input logic [IdxW-1:0] row,
                                                  input logic [IdxW-1:0] col);
    return AddrW'((32'(row) * MaxDim + 32'(col)) % StoreDepth);
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/imm_if.sv =====
// ----------------------------------------------------------------------------
// imm_if
// Valid/ready channels of the integer matrix multiply engine.
// ----------------------------------------------------------------------------
`default_nettype none

interface imm_in_if;
  logic           valid;
  logic           ready;
  imm_pkg::item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface imm_out_if;
  logic             valid;
  logic             ready;
  imm_pkg::result_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface imm_cfg_if;
  logic          valid;
  logic          ready;
  imm_pkg::cfg_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/imm_ram.sv =====
// ----------------------------------------------------------------------------
// imm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module imm_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hw/rtl/integer_matrix_multiply.sv =====
// ----------------------------------------------------------------------------
// integer_matrix_multiply
// Stores matrices A and B element by element and returns one element of A*B
// per in-range read beat, as a wrapping 128-bit sum of signed 64x64 products.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                    beat when
//  in_i     in   kind, row_index, column_index, elem value  valid & ready
//  res_o    out  status, result_low, result_high            valid & ready
//  cfg_i    in   register index, 5-bit value                valid (ready = 1)
//
//  Write beats and rejected beats: answer is registered, or held pending while res_o stalls.
//  Result read: one 33x33 signed multiplier forms the
//  four partial products of each term in turn, feeding a 128-bit accumulator.
//  in_i is not ready while a read is running or a pending response waits for res_o.
//  Reset clears control and sizes (16); the stores hold nothing defined.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_matrix_multiply (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  imm_in_if.sink    in_i,
  imm_out_if.source res_o,
  imm_cfg_if.sink   cfg_i
);

  // configuration
  logic [imm_pkg::SizeW-1:0] rows_q, inner_q, cols_q;
  logic [imm_pkg::SizeW-1:0] eff_rows, eff_inner, eff_cols;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q  <= imm_pkg::SizeW'(imm_pkg::MaxDim);
      inner_q <= imm_pkg::SizeW'(imm_pkg::MaxDim);
      cols_q  <= imm_pkg::SizeW'(imm_pkg::MaxDim);
    end else if (cfg_i.valid) begin
      case (cfg_i.data.index)
        imm_pkg::RegRows:  rows_q  <= cfg_i.data.value;
        imm_pkg::RegInner: inner_q <= cfg_i.data.value;
        imm_pkg::RegCols:  cols_q  <= cfg_i.data.value;
        default: ;
      endcase
    end
  end

  assign cfg_i.ready = 1'b1;
  assign eff_rows    = imm_pkg::eff_size(rows_q);
  assign eff_inner   = imm_pkg::eff_size(inner_q);
  assign eff_cols    = imm_pkg::eff_size(cols_q);

  // control state
  imm_pkg::state_e            state_q, state_d;
  logic [1:0]                 q_q, q_d;
  logic [imm_pkg::IdxW-1:0]   p_q, p_d;
  logic [imm_pkg::IdxW-1:0]   row_q, col_q;
  logic                       pend_q, pend_d;
  logic [imm_pkg::StatusW-1:0] pend_status_q;
  logic                       out_valid_q, out_valid_d;
  imm_pkg::result_t           out_data_q, out_data_d;
  logic                       prod_v_q;

  // input decode
  logic                        in_ready, in_fire;
  logic                        row_in_rows, row_in_inner, col_in_inner, col_in_cols;
  logic                        a_we, b_we, rd_start, wr_resp;
  logic [imm_pkg::StatusW-1:0] resp_status;

  assign in_ready    = (state_q == imm_pkg::StIdle) && !pend_q;
  assign in_i.ready  = in_ready;
  assign in_fire     = in_i.valid && in_ready;

  assign row_in_rows  = imm_pkg::SizeW'(in_i.data.row_index) < eff_rows;
  assign row_in_inner = imm_pkg::SizeW'(in_i.data.row_index) < eff_inner;
  assign col_in_inner = imm_pkg::SizeW'(in_i.data.column_index) < eff_inner;
  assign col_in_cols  = imm_pkg::SizeW'(in_i.data.column_index) < eff_cols;

  always_comb begin
    a_we        = 1'b0;
    b_we        = 1'b0;
    rd_start    = 1'b0;
    resp_status = imm_pkg::StatusRange;
    case (in_i.data.kind)
      imm_pkg::KindWriteA: begin
        if (row_in_rows && col_in_inner) begin
          a_we        = in_fire;
          resp_status = imm_pkg::StatusWriteOk;
        end
      end
      imm_pkg::KindWriteB: begin
        if (row_in_inner && col_in_cols) begin
          b_we        = in_fire;
          resp_status = imm_pkg::StatusWriteOk;
        end
      end
      imm_pkg::KindRead: begin
        if (row_in_rows && col_in_cols) begin
          rd_start    = in_fire;
          resp_status = imm_pkg::StatusValid;
        end
      end
      default: ;
    endcase
  end

  assign wr_resp = in_fire && !rd_start;

  // term walk
  logic [imm_pkg::SizeW-1:0] p_inc;
  logic                      more, step_next, re;
  logic [imm_pkg::IdxW-1:0]  p_next;
  logic [imm_pkg::AddrW-1:0] a_waddr, b_waddr, a_raddr, b_raddr;
  logic [imm_pkg::ElemW-1:0] a_rd, b_rd;

  assign p_inc     = imm_pkg::SizeW'(p_q) + imm_pkg::SizeW'(1);
  assign p_next    = p_inc[imm_pkg::IdxW-1:0];
  assign more      = p_inc < eff_inner;
  assign step_next = (state_q == imm_pkg::StMac) && (q_q == 2'd3) && more;
  assign re        = rd_start || step_next;

  assign a_waddr = imm_pkg::entry_addr(in_i.data.row_index, in_i.data.column_index);
  assign b_waddr = a_waddr;
  assign a_raddr = (state_q == imm_pkg::StIdle)
                 ? imm_pkg::entry_addr(in_i.data.row_index, '0)
                 : imm_pkg::entry_addr(row_q, p_next);
  assign b_raddr = (state_q == imm_pkg::StIdle)
                 ? imm_pkg::entry_addr('0, in_i.data.column_index)
                 : imm_pkg::entry_addr(p_next, col_q);

  imm_ram #(.Width(imm_pkg::ElemW), .Depth(imm_pkg::StoreDepth)) u_a_store (
    .clk_i   (clk_i),
    .we_i    (a_we),
    .waddr_i (a_waddr),
    .wdata_i (in_i.data.element_value),
    .re_i    (re),
    .raddr_i (a_raddr),
    .rdata_o (a_rd)
  );

  imm_ram #(.Width(imm_pkg::ElemW), .Depth(imm_pkg::StoreDepth)) u_b_store (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (b_waddr),
    .wdata_i (in_i.data.element_value),
    .re_i    (re),
    .raddr_i (b_raddr),
    .rdata_o (b_rd)
  );

  // shared multiplier: a0*b0, a0*b1, a1*b0, a1*b1 for q = 0..3
  logic signed [imm_pkg::HalfW:0]   a_half, b_half;
  logic signed [imm_pkg::PartW-1:0] prod_d, prod_q;
  logic [1:0]                       shift_d, shift_q;
  logic [imm_pkg::AccW-1:0]         prod_ext, addend, acc_q;

  assign a_half  = q_q[1] ? {a_rd[imm_pkg::ElemW-1], a_rd[imm_pkg::ElemW-1:imm_pkg::HalfW]}
                          : {1'b0, a_rd[imm_pkg::HalfW-1:0]};
  assign b_half  = q_q[0] ? {b_rd[imm_pkg::ElemW-1], b_rd[imm_pkg::ElemW-1:imm_pkg::HalfW]}
                          : {1'b0, b_rd[imm_pkg::HalfW-1:0]};
  assign prod_d  = a_half * b_half;
  assign shift_d = {1'b0, q_q[1]} + {1'b0, q_q[0]};

  assign prod_ext = {{(imm_pkg::AccW - imm_pkg::PartW){prod_q[imm_pkg::PartW-1]}}, prod_q};

  always_comb begin
    case (shift_q)
      2'd0:    addend = prod_ext;
      2'd1:    addend = prod_ext << imm_pkg::HalfW;
      2'd2:    addend = prod_ext << imm_pkg::ElemW;
      default: addend = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q  <= prod_d;
    shift_q <= shift_d;
    if (rd_start) begin
      acc_q <= '0;
      row_q <= in_i.data.row_index;
      col_q <= in_i.data.column_index;
    end else if (prod_v_q) begin
      acc_q <= acc_q + addend;
    end
  end

  // sequencer and response path
  logic out_free;
  assign out_free = !out_valid_q || res_o.ready;

  always_comb begin
    state_d     = state_q;
    q_d         = q_q;
    p_d         = p_q;
    pend_d      = pend_q;
    out_valid_d = out_valid_q && !res_o.ready;
    out_data_d  = out_data_q;
    case (state_q)
      imm_pkg::StIdle: begin
        if (rd_start) begin
          state_d = imm_pkg::StMac;
          q_d     = '0;
          p_d     = '0;
        end
      end
      imm_pkg::StMac: begin
        q_d = q_q + 2'd1;
        if (q_q == 2'd3) begin
          if (more) begin
            p_d = p_next;
          end else begin
            state_d = imm_pkg::StFlush;
          end
        end
      end
      imm_pkg::StFlush: state_d = imm_pkg::StEmit;
      imm_pkg::StEmit: begin
        if (out_free) begin
          state_d     = imm_pkg::StIdle;
          out_valid_d = 1'b1;
          out_data_d  = '{status:      imm_pkg::StatusValid,
                          result_low:  acc_q[imm_pkg::ElemW-1:0],
                          result_high: acc_q[imm_pkg::AccW-1:imm_pkg::ElemW]};
        end
      end
      default: state_d = imm_pkg::StIdle;
    endcase
    if (pend_q && out_free) begin
      pend_d      = 1'b0;
      out_valid_d = 1'b1;
      out_data_d  = '{status: pend_status_q, result_low: '0, result_high: '0};
    end else if (wr_resp) begin
      if (out_free) begin
        out_valid_d = 1'b1;
        out_data_d  = '{status: resp_status, result_low: '0, result_high: '0};
      end else begin
        pend_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= imm_pkg::StIdle;
      q_q         <= '0;
      p_q         <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      prod_v_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      q_q         <= q_d;
      p_q         <= p_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      prod_v_q    <= (state_q == imm_pkg::StMac);
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    if (wr_resp) begin
      pend_status_q <= resp_status;
    end
  end

  assign res_o.valid = out_valid_q;
  assign res_o.data  = out_data_q;

  // checks
  a_read_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_start |=> (state_q == imm_pkg::StMac) && (q_q == 2'd0) && (p_q == '0))
    else $error("read beat did not start the term walk");

  a_pend_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (state_q == imm_pkg::StIdle))
    else $error("pending response while a read is running");

  a_emit_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == imm_pkg::StEmit) && out_free |=>
      out_valid_q && (out_data_q.status == imm_pkg::StatusValid))
    else $error("finished dot product not presented");

  a_prod_from_mac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    prod_v_q |-> $past(state_q == imm_pkg::StMac))
    else $error("accumulate outside the term walk");

endmodule

`default_nettype wire
